>>> src/kie_pkg.sv
// ----------------------------------------------------------------------------
// kie_pkg
// Shared types, widths and codes of the k-mer index encoder.
// ----------------------------------------------------------------------------
package kie_pkg;

	localparam int MAX_K_DEF      = 3;
	localparam int MAX_RADIX_DEF  = 32;
	localparam int CHAR_CODES_DEF = 128;

	localparam int KMER_W     = 15;
	localparam int SYM_W      = 5;
	localparam int CODE_W     = 7;
	localparam int K_W        = 2;
	localparam int RADIX_W    = 6;
	localparam int OP_W       = 2;
	localparam int CFG_DATA_W = 6;
	localparam int CFG_ADDR_W = 1;
	localparam int REDUCE_DEPTH = 1 << KMER_W;

	localparam logic [CODE_W-1:0] FIRST_PRINTABLE = 7'h20;
	localparam logic [CODE_W-1:0] LAST_PRINTABLE  = 7'h7F;

	localparam logic [OP_W-1:0] OP_MAP  = 2'd0;
	localparam logic [OP_W-1:0] OP_RULE = 2'd1;
	localparam logic [OP_W-1:0] OP_SEQ  = 2'd2;

	localparam logic [CFG_ADDR_W-1:0] CFG_KMER_LENGTH = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] CFG_RADIX       = 1'b1;

	typedef struct packed {
		logic [OP_W-1:0]   opcode;
		logic [CODE_W-1:0] char_code;
		logic [SYM_W-1:0]  symbol_value;
		logic              symbol_mapped;
		logic [KMER_W-1:0] kmer_index;
		logic              rule_first;
		logic              seq_last;
	} item_t;

	typedef struct packed {
		logic [KMER_W-1:0] kmer_out;
		logic              kmer_valid;
		logic              bad_symbol;
		logic              sequence_ok;
		logic              end_of_sequence;
	} result_t;

	typedef struct packed {
		logic clr;
		logic accept;
		logic map_chk;
		logic calc;
		logic look;
		logic emit;
		logic rule_wr;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic kmer_go;
		logic calc_last;
		logic out_free;
	} ctrl_status_t;

endpackage

>>> src/kie_ram.sv
// ----------------------------------------------------------------------------
// kie_ram
// Generic memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module kie_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> src/kie_ctrl.sv
// ----------------------------------------------------------------------------
// kie_ctrl
// Controller state machine: clearing pass, item dispatch and result hand-off.
// ----------------------------------------------------------------------------
module kie_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	input  logic [kie_pkg::OP_W-1:0] item_opcode,
	input  logic                   item_rule_first,
	output logic                   item_ready,
	input  kie_pkg::ctrl_status_t  st,
	output kie_pkg::ctrl_cmd_t     cmd
);

	import kie_pkg::*;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_MAP   = 3'd2;
	localparam logic [2:0] S_CALC  = 3'd3;
	localparam logic [2:0] S_LOOK  = 3'd4;
	localparam logic [2:0] S_EMIT  = 3'd5;
	localparam logic [2:0] S_RULE  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       accept;

	assign item_ready = (state_q == S_IDLE);
	assign accept     = item_ready && item_valid;

	always_comb begin
		cmd         = '0;
		cmd.clr     = (state_q == S_CLEAR);
		cmd.accept  = accept;
		cmd.map_chk = (state_q == S_MAP);
		cmd.calc    = (state_q == S_CALC);
		cmd.look    = (state_q == S_LOOK);
		cmd.emit    = (state_q == S_EMIT) && st.out_free;
		cmd.rule_wr = (state_q == S_RULE);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (st.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					if (item_opcode == OP_SEQ) begin
						state_d = S_MAP;
					end else if (item_opcode == OP_RULE && item_rule_first) begin
						state_d = S_RULE;
					end
				end
			end
			S_MAP: begin
				state_d = st.kmer_go ? S_CALC : S_EMIT;
			end
			S_CALC: begin
				if (st.calc_last) begin
					state_d = S_LOOK;
				end
			end
			S_LOOK: begin
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (st.out_free) begin
					state_d = S_IDLE;
				end
			end
			S_RULE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> src/kie_dp.sv
// ----------------------------------------------------------------------------
// kie_dp
// Datapath: configuration, character map, reduction table, symbol window,
// iterative index accumulation and the result register.
// ----------------------------------------------------------------------------
module kie_dp #(
	parameter int MAX_K      = kie_pkg::MAX_K_DEF,
	parameter int MAX_RADIX  = kie_pkg::MAX_RADIX_DEF,
	parameter int CHAR_CODES = kie_pkg::CHAR_CODES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [kie_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [kie_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  kie_pkg::item_t                  item,
	output logic                            result_valid,
	input  logic                            result_ready,
	output kie_pkg::result_t                result,
	input  kie_pkg::ctrl_cmd_t              cmd,
	output kie_pkg::ctrl_status_t           st
);

	import kie_pkg::*;

	localparam int MAP_DEPTH = (CHAR_CODES < 128) ? CHAR_CODES : 128;
	localparam int MAP_AW    = $clog2(MAP_DEPTH);
	localparam int MAP_W     = SYM_W + 1;
	localparam int WIN_AW    = (MAX_K > 1) ? $clog2(MAX_K) : 1;
	localparam int RUN_W     = $clog2(MAX_K + 1);

	function automatic logic code_usable(input logic [CODE_W-1:0] code);
		code_usable = (code >= FIRST_PRINTABLE) && (code < LAST_PRINTABLE) &&
			(int'(code) < CHAR_CODES);
	endfunction

	logic [K_W-1:0]     kmer_length_q;
	logic [RADIX_W-1:0] radix_q;
	logic [RUN_W-1:0]   eff_k;
	logic [RADIX_W-1:0] eff_b;

	item_t              item_q;
	logic [SYM_W-1:0]   win_q [MAX_K];
	logic [RUN_W-1:0]   good_run_q;
	logic [RUN_W-1:0]   good_new;
	logic               seq_valid_q;
	logic [KMER_W-1:0]  rule_target_q;
	logic               reduce_active_q;
	logic [KMER_W-1:0]  clr_q;
	logic [KMER_W-1:0]  acc_q;
	logic [WIN_AW-1:0]  step_q;
	logic               kval_q;
	logic               bad_q;

	logic [WIN_AW-1:0]         win_idx;
	logic [KMER_W+RADIX_W-1:0] prod;
	logic [KMER_W-1:0]         acc_next;
	logic                      map_hit;
	logic                      rule_plain;
	logic                      rule_first_rd;

	logic               map_we;
	logic [MAP_AW-1:0]  map_waddr;
	logic [MAP_W-1:0]   map_wdata;
	logic               map_re;
	logic [MAP_W-1:0]   map_rdata;

	logic               red_we;
	logic [KMER_W-1:0]  red_waddr;
	logic [KMER_W-1:0]  red_wdata;
	logic               red_re;
	logic [KMER_W-1:0]  red_raddr;
	logic [KMER_W-1:0]  red_rdata;

	always_comb begin
		if (kmer_length_q == '0) begin
			eff_k = RUN_W'(1);
		end else if (int'(kmer_length_q) > MAX_K) begin
			eff_k = RUN_W'(MAX_K);
		end else begin
			eff_k = RUN_W'(kmer_length_q);
		end
		if (radix_q == '0) begin
			eff_b = RADIX_W'(1);
		end else if (int'(radix_q) > MAX_RADIX) begin
			eff_b = RADIX_W'(MAX_RADIX);
		end else begin
			eff_b = radix_q;
		end
	end

	assign good_new = (int'(good_run_q) < MAX_K) ? good_run_q + RUN_W'(1) : good_run_q;
	assign map_hit  = code_usable(item_q.char_code) && map_rdata[SYM_W];

	assign win_idx  = WIN_AW'(MAX_K - int'(eff_k) + int'(step_q));
	assign prod     = (KMER_W + RADIX_W)'(acc_q) * (KMER_W + RADIX_W)'(eff_b);
	assign acc_next = prod[KMER_W-1:0] + KMER_W'(win_q[win_idx]);

	assign st.clr_last  = &clr_q;
	assign st.kmer_go   = map_hit && (good_new >= eff_k);
	assign st.calc_last = (step_q == WIN_AW'(int'(eff_k) - 1));
	assign st.out_free  = !result_valid || result_ready;

	assign rule_plain    = cmd.accept && item.opcode == OP_RULE && !item.rule_first;
	assign rule_first_rd = cmd.accept && item.opcode == OP_RULE && item.rule_first;

	always_comb begin
		map_we    = (cmd.clr && int'(clr_q) < MAP_DEPTH) ||
			(cmd.accept && item.opcode == OP_MAP && code_usable(item.char_code));
		map_waddr = cmd.clr ? clr_q[MAP_AW-1:0] : item.char_code[MAP_AW-1:0];
		if (cmd.clr || !item.symbol_mapped) begin
			map_wdata = '0;
		end else begin
			map_wdata = {1'b1, item.symbol_value};
		end
		map_re = cmd.accept && item.opcode == OP_SEQ;
	end

	always_comb begin
		red_we = cmd.clr || rule_plain || cmd.rule_wr;
		if (cmd.clr) begin
			red_waddr = clr_q;
			red_wdata = clr_q;
		end else if (cmd.rule_wr) begin
			red_waddr = item_q.kmer_index;
			red_wdata = red_rdata;
		end else begin
			red_waddr = item.kmer_index;
			red_wdata = rule_target_q;
		end
		red_re    = rule_first_rd || cmd.look;
		red_raddr = cmd.look ? acc_q : item.kmer_index;
	end

	kie_ram #(
		.WIDTH(MAP_W),
		.DEPTH(MAP_DEPTH)
	) u_map_ram (
		.clk  (clk),
		.we   (map_we),
		.waddr(map_waddr),
		.wdata(map_wdata),
		.re   (map_re),
		.raddr(item.char_code[MAP_AW-1:0]),
		.rdata(map_rdata)
	);

	kie_ram #(
		.WIDTH(KMER_W),
		.DEPTH(REDUCE_DEPTH)
	) u_reduce_ram (
		.clk  (clk),
		.we   (red_we),
		.waddr(red_waddr),
		.wdata(red_wdata),
		.re   (red_re),
		.raddr(red_raddr),
		.rdata(red_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_length_q   <= K_W'(1);
			radix_q         <= RADIX_W'(4);
			clr_q           <= '0;
			rule_target_q   <= '0;
			reduce_active_q <= 1'b0;
			good_run_q      <= '0;
			seq_valid_q     <= 1'b1;
			result_valid    <= 1'b0;
			for (int i = 0; i < MAX_K; i++) begin
				win_q[i] <= '0;
			end
		end else begin
			if (cfg_we && cfg_addr == CFG_KMER_LENGTH) begin
				kmer_length_q <= cfg_wdata[K_W-1:0];
			end
			if (cfg_we && cfg_addr == CFG_RADIX) begin
				radix_q <= cfg_wdata[RADIX_W-1:0];
			end
			if (cmd.clr) begin
				clr_q <= clr_q + KMER_W'(1);
			end
			if (rule_plain) begin
				reduce_active_q <= 1'b1;
			end
			if (cmd.rule_wr) begin
				rule_target_q   <= red_rdata;
				reduce_active_q <= 1'b1;
			end
			if (cmd.map_chk) begin
				if (map_hit) begin
					for (int i = 0; i < MAX_K - 1; i++) begin
						win_q[i] <= win_q[i+1];
					end
					win_q[MAX_K-1] <= map_rdata[SYM_W-1:0];
					good_run_q     <= good_new;
				end else begin
					for (int i = 0; i < MAX_K; i++) begin
						win_q[i] <= '0;
					end
					good_run_q  <= '0;
					seq_valid_q <= 1'b0;
				end
			end
			if (cmd.emit) begin
				result_valid <= 1'b1;
				if (item_q.seq_last) begin
					for (int i = 0; i < MAX_K; i++) begin
						win_q[i] <= '0;
					end
					good_run_q  <= '0;
					seq_valid_q <= 1'b1;
				end
			end else if (result_ready) begin
				result_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q <= item;
		end
		if (cmd.map_chk) begin
			kval_q <= st.kmer_go;
			bad_q  <= !map_hit;
			acc_q  <= '0;
			step_q <= '0;
		end
		if (cmd.calc) begin
			acc_q  <= acc_next;
			step_q <= step_q + WIN_AW'(1);
		end
		if (cmd.emit) begin
			if (!kval_q) begin
				result.kmer_out <= '0;
			end else if (reduce_active_q) begin
				result.kmer_out <= red_rdata;
			end else begin
				result.kmer_out <= acc_q;
			end
			result.kmer_valid      <= kval_q;
			result.bad_symbol      <= bad_q;
			result.sequence_ok     <= seq_valid_q;
			result.end_of_sequence <= item_q.seq_last;
		end
	end

endmodule

>>> src/kmer_index_encoder_with_reduction.sv
// ----------------------------------------------------------------------------
// kmer_index_encoder_with_reduction
// Maps sequence characters to symbols, forms radix-B k-mer indexes over a
// sliding window and passes them through a loadable reduction table.
// ----------------------------------------------------------------------------
// Map loads and rule members without a first flag are done in the idle state;
// a first rule member passes through the rule state as well (read then write
// of the reduction table). A sequence character passes through the map-check
// and emit states, and also the calc and look states when a k-mer is formed:
// the index is accumulated one symbol per cycle through a single multiplier.
// After reset a pass loads the reduction table with identity and clears the
// character map; item_ready stays low meanwhile.
module kmer_index_encoder_with_reduction #(
	parameter int MAX_K      = kie_pkg::MAX_K_DEF,
	parameter int MAX_RADIX  = kie_pkg::MAX_RADIX_DEF,
	parameter int CHAR_CODES = kie_pkg::CHAR_CODES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [kie_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [kie_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  kie_pkg::item_t                 item,
	output logic                           result_valid,
	input  logic                           result_ready,
	output kie_pkg::result_t               result
);

	import kie_pkg::*;

	ctrl_cmd_t    cmd;
	ctrl_status_t st;

	kie_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_opcode    (item.opcode),
		.item_rule_first(item.rule_first),
		.item_ready     (item_ready),
		.st             (st),
		.cmd            (cmd)
	);

	kie_dp #(
		.MAX_K     (MAX_K),
		.MAX_RADIX (MAX_RADIX),
		.CHAR_CODES(CHAR_CODES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result),
		.cmd         (cmd),
		.st          (st)
	);

endmodule

>>> src/kie_checker.sv
// ----------------------------------------------------------------------------
// kie_checker
// Port-level checks on the result channel of the k-mer index encoder.
// ----------------------------------------------------------------------------
module kie_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             result_valid,
	input logic             result_ready,
	input kie_pkg::result_t result
);

	import kie_pkg::*;

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("Stalled result transaction changed or was dropped.");

	a_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.kmer_valid |-> result.kmer_out == '0)
		else $error("A result without a k-mer carries a nonzero index.");

	a_bad_symbol: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.bad_symbol |-> !result.kmer_valid && !result.sequence_ok)
		else $error("A bad symbol result shows a k-mer or a good sequence.");

endmodule

bind kmer_index_encoder_with_reduction kie_checker u_kie_checker (.*);

>>> test/tb_kmer_index_encoder_with_reduction.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kmer_index_encoder_with_reduction
// Self-checking testbench for the k-mer index encoder. A behavioral copy of
// the encoder (character map, symbol window, reduction table) predicts every
// result at the moment its input transaction is accepted, and each result
// transaction is compared field by field against the oldest prediction.
// Directed tests cover the map, the special characters and the reduction
// rules; random traffic then runs over several k and radix settings with
// random idling on both sides and one long hold-off of the result side.
// ----------------------------------------------------------------------------
module tb_kmer_index_encoder_with_reduction;
	import kie_pkg::*;

	localparam int WIN_DEPTH = MAX_K_DEF;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 12;
	localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic item_valid;
	logic item_ready;
	item_t item_bus;
	logic result_valid;
	logic result_ready;
	result_t result_bus;

	logic [5:0] char_tab [CHAR_CODES_DEF];
	logic [KMER_W-1:0] reduce_tab [REDUCE_DEPTH];
	logic [SYM_W-1:0] sym_win [WIN_DEPTH];
	int unsigned held_syms;
	bit seq_good;
	logic [KMER_W-1:0] rule_target;
	bit reduce_on;
	logic [K_W-1:0] k_reg;
	logic [RADIX_W-1:0] radix_reg;

	result_t expected_kmers [$];
	int error_count;
	bit quiet;
	bit hold_results;

	kmer_index_encoder_with_reduction DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item_bus),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result_bus)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#800000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic bit printable(input logic [CODE_W-1:0] code);
		return code >= FIRST_PRINTABLE && code < LAST_PRINTABLE;
	endfunction

	function automatic void clear_window();
		for (int i = 0; i < WIN_DEPTH; i++) sym_win[i] = '0;
		held_syms = 0;
	endfunction

	function automatic void predict_kmer(input item_t it);
		result_t r;
		logic [5:0] entry;
		int unsigned k_eff;
		int unsigned base;
		int unsigned acc;
		logic [KMER_W-1:0] idx;
		r = '0;
		if (it.opcode == OP_MAP) begin
			if (printable(it.char_code))
				char_tab[it.char_code] = it.symbol_mapped ? {1'b1, it.symbol_value} : 6'd0;
			return;
		end
		if (it.opcode == OP_RULE) begin
			if (it.rule_first) rule_target = reduce_tab[it.kmer_index];
			reduce_tab[it.kmer_index] = rule_target;
			reduce_on = 1'b1;
			return;
		end
		if (it.opcode != OP_SEQ) return;
		entry = char_tab[it.char_code];
		if (printable(it.char_code) && entry[5]) begin
			for (int i = 0; i + 1 < WIN_DEPTH; i++) sym_win[i] = sym_win[i + 1];
			sym_win[WIN_DEPTH - 1] = entry[SYM_W-1:0];
			if (held_syms < WIN_DEPTH) held_syms++;
			k_eff = (k_reg == 0) ? 1 : k_reg;
			base = (radix_reg == 0) ? 1 : ((radix_reg > MAX_RADIX_DEF) ? MAX_RADIX_DEF : radix_reg);
			if (held_syms >= k_eff) begin
				acc = 0;
				for (int i = WIN_DEPTH - k_eff; i < WIN_DEPTH; i++) acc = acc * base + sym_win[i];
				idx = acc[KMER_W-1:0];
				r.kmer_out = reduce_on ? reduce_tab[idx] : idx;
				r.kmer_valid = 1'b1;
			end
		end else begin
			r.bad_symbol = 1'b1;
			clear_window();
			seq_good = 1'b0;
		end
		r.sequence_ok = seq_good;
		r.end_of_sequence = it.seq_last;
		expected_kmers.push_back(r);
		if (it.seq_last) begin
			clear_window();
			seq_good = 1'b1;
		end
	endfunction

	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (expected_kmers.size() == 0) begin
					$error("Result transaction arrived with no expected result pending.");
					error_count++;
				end else begin
					exp_r = expected_kmers.pop_front();
					if (result_bus.kmer_out !== exp_r.kmer_out) begin
						$error("kmer_out expected %0d got %0d", exp_r.kmer_out, result_bus.kmer_out);
						error_count++;
					end
					if (result_bus.kmer_valid !== exp_r.kmer_valid) begin
						$error("kmer_valid expected %0b got %0b", exp_r.kmer_valid,
							result_bus.kmer_valid);
						error_count++;
					end
					if (result_bus.bad_symbol !== exp_r.bad_symbol) begin
						$error("bad_symbol expected %0b got %0b", exp_r.bad_symbol,
							result_bus.bad_symbol);
						error_count++;
					end
					if (result_bus.sequence_ok !== exp_r.sequence_ok) begin
						$error("sequence_ok expected %0b got %0b", exp_r.sequence_ok,
							result_bus.sequence_ok);
						error_count++;
					end
					if (result_bus.end_of_sequence !== exp_r.end_of_sequence) begin
						$error("end_of_sequence expected %0b got %0b", exp_r.end_of_sequence,
							result_bus.end_of_sequence);
						error_count++;
					end
				end
			end
			if (item_valid && item_ready) predict_kmer(item_bus);
		end
	end

	initial begin
		result_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_results) begin
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_results = 1'b0;
			end
			result_ready <= quiet || ($urandom_range(99) >= 19);
		end
	end

	task automatic send_item(input item_t it);
		int gap;
		gap = 0;
		if (!quiet) while ($urandom_range(99) < 19) gap++;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item_bus <= it;
		do @(posedge clk); while (!item_ready);
	endtask

	task automatic wait_idle();
		item_valid <= 1'b0;
		while (expected_kmers.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [K_W-1:0] k, input logic [RADIX_W-1:0] radix);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_addr <= CFG_KMER_LENGTH;
		cfg_wdata <= {4'($urandom), k};
		@(posedge clk);
		cfg_addr <= CFG_RADIX;
		cfg_wdata <= radix;
		@(posedge clk);
		cfg_we <= 1'b0;
		k_reg = k;
		radix_reg = radix;
	endtask

	function automatic item_t rand_item(input logic [OP_W-1:0] op);
		item_t it;
		it = item_t'($urandom);
		it.opcode = op;
		return it;
	endfunction

	function automatic item_t map_item(input logic [CODE_W-1:0] code, input logic [SYM_W-1:0] sym,
		input logic mapped);
		item_t it;
		it = rand_item(OP_MAP);
		it.char_code = code;
		it.symbol_value = sym;
		it.symbol_mapped = mapped;
		return it;
	endfunction

	function automatic item_t seq_item(input logic [CODE_W-1:0] code, input logic last);
		item_t it;
		it = rand_item(OP_SEQ);
		it.char_code = code;
		it.seq_last = last;
		return it;
	endfunction

	function automatic item_t rule_item(input logic [KMER_W-1:0] idx, input logic first);
		item_t it;
		it = rand_item(OP_RULE);
		it.kmer_index = idx;
		it.rule_first = first;
		return it;
	endfunction

	function automatic logic [CODE_W-1:0] letter();
		return 7'h41 + CODE_W'($urandom_range(25));
	endfunction

	task automatic map_letters();
		int unsigned lim;
		logic [SYM_W-1:0] sym;
		lim = (radix_reg == 0) ? 1 : ((radix_reg > MAX_RADIX_DEF) ? MAX_RADIX_DEF : radix_reg);
		for (int c = 0; c < 26; c++) begin
			sym = ($urandom_range(3) != 0) ? SYM_W'($urandom_range(lim - 1)) : SYM_W'($urandom);
			send_item(map_item(7'h41 + CODE_W'(c), sym, 1'b1));
		end
	endtask

	task automatic test_unmapped_after_reset();
		send_item(seq_item(CODE_W'("A"), 1'b0));
		send_item(seq_item(7'h00, 1'b1));
	endtask

	task automatic test_char_map();
		set_config(2'd3, 6'd4);
		send_item(map_item(CODE_W'("A"), 5'd0, 1'b1));
		send_item(map_item(CODE_W'("C"), 5'd1, 1'b1));
		send_item(map_item(CODE_W'("G"), 5'd2, 1'b1));
		send_item(map_item(CODE_W'("T"), 5'd3, 1'b1));
		send_item(map_item(7'h1F, 5'd5, 1'b1));
		send_item(map_item(7'h7F, 5'd6, 1'b1));
		send_item(map_item(7'h20, 5'd31, 1'b1));
		send_item(map_item(7'h7E, 5'd31, 1'b1));
		send_item(seq_item(CODE_W'("A"), 1'b0));
		send_item(seq_item(CODE_W'("C"), 1'b0));
		send_item(seq_item(CODE_W'("G"), 1'b0));
		send_item(seq_item(CODE_W'("T"), 1'b0));
		send_item(seq_item(7'h7E, 1'b0));
		send_item(seq_item(7'h20, 1'b1));
		send_item(seq_item(7'h1F, 1'b0));
		send_item(seq_item(7'h7F, 1'b0));
		send_item(seq_item(CODE_W'("A"), 1'b1));
		send_item(map_item(CODE_W'("T"), 5'd3, 1'b0));
		send_item(seq_item(CODE_W'("T"), 1'b1));
	endtask

	task automatic test_reduction_rules();
		send_item(rule_item(15'd3, 1'b0));
		send_item(rule_item(15'd6, 1'b1));
		send_item(rule_item(15'd27, 1'b0));
		send_item(rule_item(15'h7FFF, 1'b0));
		send_item(rule_item(15'h7FFF, 1'b1));
		send_item(rand_item(OP_IGNORED));
		send_item(seq_item(CODE_W'("A"), 1'b0));
		send_item(seq_item(CODE_W'("C"), 1'b0));
		send_item(seq_item(CODE_W'("G"), 1'b1));
	endtask

	task automatic test_random_traffic(input int n);
		int sent;
		int len;
		bit broken;
		item_t it;
		sent = 0;
		while (sent < n) begin
			case ($urandom_range(9))
				0: begin
					it = rand_item(OP_W'($urandom));
					send_item(it);
					if (it.opcode != OP_IGNORED) sent++;
				end
				1: begin
					len = $urandom_range(1, 4);
					for (int i = 0; i < len; i++)
						send_item(rule_item(($urandom_range(4) == 0) ? KMER_W'($urandom) :
							KMER_W'($urandom_range(255)), (i == 0) && ($urandom_range(7) != 0)));
					sent += len;
				end
				2: begin
					send_item(map_item(($urandom_range(3) != 0) ? letter() : CODE_W'($urandom),
						SYM_W'($urandom), $urandom_range(9) != 0));
					sent++;
				end
				default: begin
					len = $urandom_range(1, 10);
					broken = ($urandom_range(9) == 0);
					for (int i = 0; i < len; i++)
						send_item(seq_item(($urandom_range(99) < 92) ? letter() : CODE_W'($urandom),
							(i == len - 1) && !broken));
					sent += len;
				end
			endcase
		end
	endtask

	task automatic test_config_sweep();
		logic [K_W-1:0] ks [6] = '{2'd0, 2'd3, 2'd2, 2'd1, 2'd3, 2'd2};
		logic [RADIX_W-1:0] rs [6] = '{6'd0, 6'd63, 6'd33, 6'd1, 6'd32, 6'd7};
		for (int s = 0; s < 6; s++) begin
			set_config(ks[s], rs[s]);
			map_letters();
			test_random_traffic(40);
		end
	endtask

	task automatic test_result_backpressure();
		quiet = 1'b1;
		hold_results = 1'b1;
		for (int i = 0; i < 60; i++) send_item(seq_item(letter(), (i % 10) == 9));
		quiet = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_addr <= '0;
		cfg_wdata <= '0;
		item_valid <= 1'b0;
		item_bus <= '0;
		error_count = 0;
		quiet = 1'b0;
		hold_results = 1'b0;
		k_reg = 2'd1;
		radix_reg = 6'd4;
		for (int i = 0; i < CHAR_CODES_DEF; i++) char_tab[i] = '0;
		for (int i = 0; i < REDUCE_DEPTH; i++) reduce_tab[i] = KMER_W'(i);
		clear_window();
		seq_good = 1'b1;
		rule_target = '0;
		reduce_on = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_unmapped_after_reset();
		test_char_map();
		test_reduction_rules();
		test_config_sweep();
		set_config(2'd3, 6'd4);
		map_letters();
		test_random_traffic(300);
		quiet = 1'b1;
		test_random_traffic(150);
		quiet = 1'b0;
		test_random_traffic(150);
		test_result_backpressure();

		wait_idle();
		repeat (20) @(posedge clk);
		if (error_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
